@@ rtl/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// Spherical checker texture package
// Shared widths, the CORDIC angle table and the register index codes.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int CordicStagesDefault = 16;
    localparam int CoordW = 32;
    localparam int AngW = 32;
    localparam int DatW = 36;
    localparam int UW = 16;
    localparam int VW = 17;
    localparam int ChkW = 16;
    localparam int ColW = 24;
    localparam int CfgIdxW = 2;
    localparam logic signed [31:0] GainQ30 = 32'sd1768195363;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CHECKS_U    = 2'd0,
        REG_CHECKS_V    = 2'd1,
        REG_COLOUR_EVEN = 2'd2,
        REG_COLOUR_ODD  = 2'd3
    } t_reg_idx;

    function automatic logic [AngW-1:0] atan_turn(input int i);
        logic [AngW-1:0] t;
        begin
            unique case (i)
                0: t = 32'h20000000;  1: t = 32'h12E4051E;
                2: t = 32'h09FB385B;  3: t = 32'h051111D4;
                4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
                6: t = 32'h00A2F61E;  7: t = 32'h00517C55;
                8: t = 32'h0028BE53;  9: t = 32'h00145F2F;
                10: t = 32'h000A2F98; 11: t = 32'h000517CC;
                12: t = 32'h00028BE6; 13: t = 32'h000145F3;
                14: t = 32'h0000A2FA; 15: t = 32'h0000517D;
                16: t = 32'h000028BE; 17: t = 32'h0000145F;
                18: t = 32'h00000A30; 19: t = 32'h00000518;
                20: t = 32'h0000028C; 21: t = 32'h00000146;
                22: t = 32'h000000A3; 23: t = 32'h00000051;
                24: t = 32'h00000029; 25: t = 32'h00000014;
                26: t = 32'h0000000A; 27: t = 32'h00000005;
                28: t = 32'h00000003; 29: t = 32'h00000001;
                30: t = 32'h00000001;
                default: t = 32'h00000000;
            endcase
            return t;
        end
    endfunction

endpackage

@@ rtl/sct_cordic.sv @@
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// One register stage per iteration plus a pre-rotation stage; the angle is a
// 32-bit binary angle and the magnitude carries the CORDIC gain.
// ----------------------------------------------------------------------------
module sct_cordic #(
    parameter int STAGES = sct_pkg::CordicStagesDefault,
    parameter int SW = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [sct_pkg::DatW-1:0]   i_b,
    input  logic signed [sct_pkg::DatW-1:0]   i_a,
    input  logic [SW-1:0]                     i_side,
    output logic                              o_valid,
    output logic [sct_pkg::AngW-1:0]          o_ang,
    output logic signed [sct_pkg::DatW-1:0]   o_mag,
    output logic [SW-1:0]                     o_side
);
    localparam int DW = sct_pkg::DatW;
    localparam int AW = sct_pkg::AngW;

    logic                 r_v [STAGES+1];
    logic signed [DW-1:0] r_b [STAGES+1];
    logic signed [DW-1:0] r_a [STAGES+1];
    logic [AW-1:0]        r_acc [STAGES+1];
    logic                 r_z [STAGES+1];
    logic [SW-1:0]        r_s [STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_z[0] <= (i_a == '0) && (i_b == '0);
            r_s[0] <= i_side;
            if (i_b < 0) begin
                r_b[0] <= -i_b;
                r_a[0] <= -i_a;
                r_acc[0] <= 32'h80000000;
            end else begin
                r_b[0] <= i_b;
                r_a[0] <= i_a;
                r_acc[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_z[g+1] <= r_z[g];
                r_s[g+1] <= r_s[g];
                if (g >= 32) begin
                    r_b[g+1] <= r_b[g];
                    r_a[g+1] <= r_a[g];
                    r_acc[g+1] <= r_acc[g];
                end else if (r_a[g] >= 0) begin
                    r_b[g+1] <= r_b[g] + (r_a[g] >>> g);
                    r_a[g+1] <= r_a[g] - (r_b[g] >>> g);
                    r_acc[g+1] <= r_acc[g] + sct_pkg::atan_turn(g);
                end else begin
                    r_b[g+1] <= r_b[g] - (r_a[g] >>> g);
                    r_a[g+1] <= r_a[g] + (r_b[g] >>> g);
                    r_acc[g+1] <= r_acc[g] - sct_pkg::atan_turn(g);
                end
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_side  = r_s[STAGES];
    assign o_ang   = r_z[STAGES] ? '0 : r_acc[STAGES];
    assign o_mag   = (r_z[STAGES] || r_b[STAGES] < 0) ? '0 : r_b[STAGES];
endmodule

@@ rtl/sct_shade.sv @@
// ----------------------------------------------------------------------------
// Checker shading stages
// Turns the two angles into texture coordinates, check parity and colour.
// ----------------------------------------------------------------------------
module sct_shade (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [sct_pkg::AngW-1:0]     i_theta,
    input  logic [sct_pkg::AngW-1:0]     i_phi,
    input  logic [sct_pkg::ChkW-1:0]     i_checks_u,
    input  logic [sct_pkg::ChkW-1:0]     i_checks_v,
    input  logic [sct_pkg::ColW-1:0]     i_col_even,
    input  logic [sct_pkg::ColW-1:0]     i_col_odd,
    output logic                         o_valid,
    output logic [sct_pkg::UW-1:0]       o_u,
    output logic [sct_pkg::VW-1:0]       o_v,
    output logic                         o_odd,
    output logic [sct_pkg::ColW-1:0]     o_col
);
    logic [31:0] phic, uturn, vturn;
    logic        r_v1, r_v2;
    logic [15:0] r_u1, r_u2;
    logic [16:0] r_tv1, r_tv2;
    logic [32:0] r_pu, r_pv;

    always_comb begin
        if (i_phi >= 32'hC0000000) begin
            phic = '0;
        end else if (i_phi > 32'h80000000) begin
            phic = 32'h80000000;
        end else begin
            phic = i_phi;
        end
        uturn = 32'h80000000 - i_theta;
        vturn = 32'h80000000 - phic;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_u1  <= uturn[31:16];
            r_tv1 <= vturn[31:15];
            r_u2  <= r_u1;
            r_tv2 <= r_tv1;
            r_pu  <= 33'(r_u1 * i_checks_u);
            r_pv  <= 33'(r_tv1 * i_checks_v);
        end
    end

    assign o_valid = r_v2;
    assign o_u     = r_u2;
    assign o_v     = r_tv2;
    assign o_odd   = r_pu[24] ^ r_pv[24];
    assign o_col   = o_odd ? i_col_odd : i_col_even;
endmodule

@@ rtl/spherical_checker_texture_core.sv @@
// ----------------------------------------------------------------------------
// Spherical checker texture core
// Maps a Q16.16 point onto a sphere and returns u, v, parity and colour.
// ----------------------------------------------------------------------------
// The block takes one point per cycle while the output is not stalled. The
// pipeline is made of two chained pipelined CORDICs of
// CORDIC_STAGES + 1 stages each, one gain multiply stage, two shading stages
// and the output register. A stall on the output freezes the whole
// pipeline; the input is ready whenever the output register is empty or its
// beat is being taken in the same cycle.
module spherical_checker_texture_core #(
    parameter int CORDIC_STAGES = sct_pkg::CordicStagesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // point_x, point_y, point_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // tex_u, tex_v, odd_square, colour, pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int DW = sct_pkg::DatW;

    logic [15:0] r_checks_u, r_checks_v;
    logic [23:0] r_col_even, r_col_odd;
    logic        en;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_checks_u <= 16'd4096;
            r_checks_v <= 16'd2048;
            r_col_even <= 24'hFFFFFF;
            r_col_odd  <= '0;
        end else if (i_cfg_valid) begin
            unique case (sct_pkg::t_reg_idx'(i_cfg_index))
                sct_pkg::REG_CHECKS_U:    r_checks_u <= i_cfg_data[15:0];
                sct_pkg::REG_CHECKS_V:    r_checks_v <= i_cfg_data[15:0];
                sct_pkg::REG_COLOUR_EVEN: r_col_even <= i_cfg_data[23:0];
                sct_pkg::REG_COLOUR_ODD:  r_col_odd  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    logic sh_valid;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [31:0] px, py, pz;
    assign px = s_axis_tdata[31:0];
    assign py = s_axis_tdata[63:32];
    assign pz = s_axis_tdata[95:64];

    logic                 c1_v;
    logic [31:0]          c1_ang, c1_y;
    logic signed [DW-1:0] c1_mag;

    sct_cordic #(.STAGES(CORDIC_STAGES), .SW(32)) u_theta (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid),
        .i_b(DW'(pz)), .i_a(DW'(px)), .i_side(py),
        .o_valid(c1_v), .o_ang(c1_ang), .o_mag(c1_mag), .o_side(c1_y)
    );

    logic                 r_g_v;
    logic signed [63:0]   r_g_prod;
    logic signed [DW-1:0] r_g_mag;
    logic [31:0]          r_g_th;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (en) begin
            r_g_v <= c1_v;
        end
        if (en) begin
            r_g_prod <= $signed(c1_y) * sct_pkg::GainQ30;
            r_g_mag  <= c1_mag;
            r_g_th   <= c1_ang;
        end
    end

    logic                 c2_v;
    logic [31:0]          c2_ang, c2_th;
    logic signed [DW-1:0] c2_mag;
    sct_cordic #(.STAGES(CORDIC_STAGES), .SW(32)) u_phi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_g_v),
        .i_b(DW'(r_g_prod >>> 30)), .i_a(r_g_mag), .i_side(r_g_th),
        .o_valid(c2_v), .o_ang(c2_ang), .o_mag(c2_mag), .o_side(c2_th)
    );

    logic [15:0] sh_u;
    logic [16:0] sh_v;
    logic        sh_odd;
    logic [23:0] sh_col;
    sct_shade u_shade (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(c2_v),
        .i_theta(c2_th), .i_phi(c2_ang),
        .i_checks_u(r_checks_u), .i_checks_v(r_checks_v),
        .i_col_even(r_col_even), .i_col_odd(r_col_odd),
        .o_valid(sh_valid), .o_u(sh_u), .o_v(sh_v), .o_odd(sh_odd), .o_col(sh_col)
    );

    logic        r_o_v;
    logic [57:0] r_o_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= sh_valid;
        end
        if (en) begin
            r_o_d <= {sh_col, sh_odd, sh_v, sh_u};
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {6'd0, r_o_d};

    logic unused_mag;
    assign unused_mag = ^c2_mag;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed during stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sh_valid && en |=> r_o_d[57:34] == ($past(sh_odd) ? $past(r_col_odd)
                                                           : $past(r_col_even)))
        else $error("colour does not follow parity");
endmodule

@@ tb/spherical_checker_texture_core_tb.sv @@
// ----------------------------------------------------------------------------
// Spherical checker texture core testbench
// Streams Q16.16 points through the core and checks u, v, parity and colour
// against a bit-exact CORDIC predictor across several register settings.
// ----------------------------------------------------------------------------
module spherical_checker_texture_core_tb;

    localparam int Stages = sct_pkg::CordicStagesDefault;
    localparam int Latency = 2 * Stages + 6;
    localparam longint CycleLimit = 400000;

    typedef struct packed {
        logic [sct_pkg::ColW-1:0] colour;
        logic                     odd_square;
        logic [sct_pkg::VW-1:0]   tex_v;
        logic [sct_pkg::UW-1:0]   tex_u;
    } t_shade;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    logic [15:0] checks_u_q;
    logic [15:0] checks_v_q;
    logic [23:0] colour_even_q;
    logic [23:0] colour_odd_q;

    t_shade shade_q[$];
    int     fail_cnt = 0;
    int     point_cnt = 0;
    int     shade_cnt = 0;
    int     odd_cnt = 0;
    bit     quiet = 1'b0;
    longint cycle_cnt = 0;

    spherical_checker_texture_core #(.CORDIC_STAGES(Stages)) u_top (.*);

    always #2 i_clk = ~i_clk;

    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] vector_turn(input longint b_in, input longint a_in,
                                                output longint mag);
        logic [31:0] acc;
        longint      b;
        longint      a;
        longint      nb;
        acc = '0;
        b = b_in;
        a = a_in;
        if (a == 0 && b == 0) begin
            mag = 0;
            return '0;
        end
        if (b < 0) begin
            b = -b;
            a = -a;
            acc = 32'h80000000;
        end
        for (int i = 0; i < Stages; i++) begin
            if (a >= 0) begin
                nb = b + shr_floor(a, i);
                a = a - shr_floor(b, i);
                acc = acc + sct_pkg::atan_turn(i);
            end else begin
                nb = b - shr_floor(a, i);
                a = a + shr_floor(b, i);
                acc = acc - sct_pkg::atan_turn(i);
            end
            b = nb;
        end
        mag = (b < 0) ? 0 : b;
        return acc;
    endfunction

    function automatic t_shade shade_point(input logic [31:0] px, input logic [31:0] py,
                                           input logic [31:0] pz);
        t_shade      r;
        longint      rho;
        longint      dummy;
        longint      yk;
        logic [31:0] theta;
        logic [31:0] phi;
        logic [31:0] uturn;
        logic [63:0] iu;
        logic [63:0] iv;
        theta = vector_turn(longint'(signed'(pz)), longint'(signed'(px)), rho);
        uturn = 32'h80000000 - theta;
        r.tex_u = uturn[31:16];
        yk = shr_floor(longint'(signed'(py)) * longint'(sct_pkg::GainQ30), 30);
        phi = vector_turn(yk, rho, dummy);
        if (phi >= 32'hC0000000) phi = '0;
        else if (phi > 32'h80000000) phi = 32'h80000000;
        r.tex_v = 17'((32'h80000000 - phi) >> 15);
        iu = (64'(r.tex_u) * 64'(checks_u_q)) >> 24;
        iv = (64'(r.tex_v) * 64'(checks_v_q)) >> 24;
        r.odd_square = iu[0] ^ iv[0];
        r.colour = r.odd_square ? colour_odd_q : colour_even_q;
        return r;
    endfunction

    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz);
        idle_gap();
        s_axis_tdata <= {pz, py, px};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        shade_q.push_back(shade_point(px, py, pz));
        point_cnt++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (shade_q.size() != 0) @(negedge i_clk);
        repeat (Latency + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(input sct_pkg::t_reg_idx idx, input logic [31:0] value);
        i_cfg_index <= idx;
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            sct_pkg::REG_CHECKS_U:    checks_u_q = value[15:0];
            sct_pkg::REG_CHECKS_V:    checks_v_q = value[15:0];
            sct_pkg::REG_COLOUR_EVEN: colour_even_q = value[23:0];
            sct_pkg::REG_COLOUR_ODD:  colour_odd_q = value[23:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_all(input logic [31:0] cu, input logic [31:0] cv,
                           input logic [31:0] ce, input logic [31:0] co);
        drain();
        write_reg(sct_pkg::REG_CHECKS_U, cu);
        write_reg(sct_pkg::REG_CHECKS_V, cv);
        write_reg(sct_pkg::REG_COLOUR_EVEN, ce);
        write_reg(sct_pkg::REG_COLOUR_ODD, co);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000);
            2: return 32'($signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000);
            default: return (1 << $urandom_range(0, 31)) ^ ($urandom_range(0, 1) ? '1 : '0);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] e[6];
        e = '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
              32'hFFFF0000, 32'hFFFFFFFF};
        send_point(0, 0, 0);
        send_point(0, 32'h00010000, 0);
        send_point(0, 32'hFFFF0000, 0);
        send_point(0, 32'h7FFFFFFF, 0);
        send_point(0, 32'h80000000, 0);
        for (int i = 0; i < 6; i++)
            for (int j = 1; j < 4; j++) send_point(e[i], e[(i + j) % 6], e[(i + 2 * j) % 6]);
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++) send_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic test_pause();
        test_random(20);
        drain();
        test_random(20);
    endtask

    task automatic test_settings();
        set_all(16'hFFFF, 16'hFFFF, 24'h123456, 24'hFEDCBA);
        test_random(200);
        set_all(0, 0, 24'h000000, 24'hFFFFFF);
        test_random(100);
        set_all($urandom(), $urandom(), $urandom(), $urandom());
        test_random(200);
        set_all(16'h0100, 16'h0001, 24'hAA55AA, 24'h55AA55);
        test_random(200);
    endtask

    always @(negedge i_clk) begin
        if (quiet) m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 4) == 0) m_axis_tready <= ~m_axis_tready;
        else if (!m_axis_tready) m_axis_tready <= ($urandom_range(0, 2) == 0);
    end

    always @(posedge i_clk) begin
        t_shade got;
        t_shade want;
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_shade'(m_axis_tdata[57:0]);
            if (shade_q.size() == 0) begin
                $error("result beat with no pending point");
                fail_cnt++;
            end else begin
                want = shade_q.pop_front();
                shade_cnt++;
                odd_cnt += got.odd_square;
                if (got.tex_u !== want.tex_u) begin
                    $error("tex_u exp %0d got %0d", want.tex_u, got.tex_u);
                    fail_cnt++;
                end
                if (got.tex_v !== want.tex_v) begin
                    $error("tex_v exp %0d got %0d", want.tex_v, got.tex_v);
                    fail_cnt++;
                end
                if (got.odd_square !== want.odd_square) begin
                    $error("odd_square exp %0d got %0d", want.odd_square, got.odd_square);
                    fail_cnt++;
                end
                if (got.colour !== want.colour) begin
                    $error("colour exp %06h got %06h", want.colour, got.colour);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        checks_u_q = 16'd4096;
        checks_v_q = 16'd2048;
        colour_even_q = 24'hFFFFFF;
        colour_odd_q = 24'h000000;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_pause();
        test_settings();
        quiet = 1'b1;
        test_random(300);
        drain();
        $display("Sent %0d points over five register settings; %0d results checked, %0d odd.",
                 point_cnt, shade_cnt, odd_cnt);
        if (fail_cnt == 0 && shade_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ spherical_checker_texture_core.f @@
rtl/sct_pkg.sv
rtl/sct_cordic.sv
rtl/sct_shade.sv
rtl/spherical_checker_texture_core.sv
tb/spherical_checker_texture_core_tb.sv
